[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Standalone header; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/lcc_pkg.sv]
// Shared types, field widths and mode codes of the LRU client cache.
// No dependencies; used by the store, the top level, the checker and the testbench.
package lcc_pkg;

	localparam int MODE_W = 2;
	localparam int KEY_W  = 9;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 7;

	// Transaction modes on the request channel.
	localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CONFIRM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DATA    = 2'd2;

	// One cache line: tag, item update time, payload and item kind.
	typedef struct packed {
		logic [KEY_W-1:0]  tag;
		logic [TIME_W-1:0] utime;
		logic [TIME_W-1:0] value;
		logic              hot;
	} lcc_entry_t;

	// Strobes from the sequencer to the line and use-stamp memories.
	typedef struct packed {
		logic rd_en;
		logic entry_we;
		logic stamp_we;
	} lcc_ctl_t;

	// Counter increment that sticks at all ones.
	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		return (v == {TIME_W{1'b1}}) ? v : v + TIME_W'(1);
	endfunction

endpackage

[src/lru_client_cache_with_validation_core.sv]
// Fully associative client cache with LRU replacement; one transaction in flight at a time.
// Lookup: tag scan, one line per cycle, stops at first match.
// Data reply: writes the matched or next free line, or scans use stamps for a victim.
// Confirm: reads and restamps the line of a matched lookup; the unused mode only replies.
// Reset clears the fill count, pending lookup, counters, warm flag and handshakes;
// the memories are not cleared, lines above the fill count are never read.
module lru_client_cache_with_validation_core #(
	parameter int ENTRIES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [lcc_pkg::MODE_W-1:0]    mode,
	input  logic [lcc_pkg::KEY_W-1:0]     item_key,
	input  logic [lcc_pkg::TIME_W-1:0]    now,
	input  logic [lcc_pkg::TIME_W-1:0]    reply_time,
	input  logic [lcc_pkg::TIME_W-1:0]    reply_value,
	input  logic                          reply_hot,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          found,
	output logic [lcc_pkg::SLOT_W-1:0]    slot,
	output logic [lcc_pkg::TIME_W-1:0]    cached_time,
	output logic [lcc_pkg::TIME_W-1:0]    query_count,
	output logic [lcc_pkg::TIME_W-1:0]    hit_count,
	output logic                          evicted,
	output logic                          warmed
);
	import lcc_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [CNT_W-1:0] ENT_C = CNT_W'(ENTRIES);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LOOK    = 3'd1;
	localparam logic [2:0] ST_LRU     = 3'd2;
	localparam logic [2:0] ST_CONF_RD = 3'd3;
	localparam logic [2:0] ST_CONF_WT = 3'd4;
	localparam logic [2:0] ST_WRITE   = 3'd5;
	localparam logic [2:0] ST_RESULT  = 3'd6;

	// Control state.
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  fill_q;
	logic              pend_found_q;
	logic [IDX_W-1:0]  pend_slot_q;
	logic [TIME_W-1:0] queries_q;
	logic [TIME_W-1:0] hits_q;
	logic              warm_q;
	logic [CNT_W-1:0]  idx_q;
	logic              iss_s1;
	logic              have_best_q;
	logic              res_found_q;
	logic              res_ev_q;
	logic              rsp_valid_q;
	logic              found_q;
	logic              evicted_q;
	logic              warmed_q;

	// Datapath registers.
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] rtime_q;
	logic [TIME_W-1:0] rvalue_q;
	logic              rhot_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  best_q;
	logic [TIME_W-1:0] best_stamp_q;
	logic [IDX_W-1:0]  work_slot_q;
	logic [IDX_W-1:0]  res_slot_q;
	logic [TIME_W-1:0] res_ctime_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] ctime_q;
	logic [TIME_W-1:0] qcnt_q;
	logic [TIME_W-1:0] hcnt_q;

	// Memory interface.
	lcc_ctl_t          ctl;
	logic [IDX_W-1:0]  rd_addr;
	lcc_entry_t        wr_entry;
	lcc_entry_t        rd_entry;
	logic [TIME_W-1:0] rd_stamp;

	logic              acc;
	logic              out_free;
	logic              issue;
	logic              match;
	logic              look_done;
	logic              lru_take;
	logic              lru_done;
	logic [WIDE_W-1:0] res_slot_wide;

	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Scan issue: one memory read per cycle while lines remain.
	assign issue = ((state_q == ST_LOOK) && (idx_q < fill_q)) ||
		((state_q == ST_LRU) && (idx_q < ENT_C));
	assign match     = iss_s1 && (rd_entry.tag == key_q);
	assign look_done = (state_q == ST_LOOK) && (match || !(idx_q < fill_q));
	assign lru_take  = (state_q == ST_LRU) && iss_s1 &&
		(!have_best_q || (rd_stamp < best_stamp_q));
	assign lru_done  = (state_q == ST_LRU) && !(idx_q < ENT_C) && !iss_s1;

	// Memory strobes and addresses.
	always_comb begin
		ctl.rd_en    = issue || (state_q == ST_CONF_RD);
		ctl.entry_we = (state_q == ST_WRITE);
		ctl.stamp_we = (state_q == ST_WRITE) || (state_q == ST_CONF_RD);
		rd_addr      = (state_q == ST_CONF_RD) ? work_slot_q : idx_q[IDX_W-1:0];
	end

	assign wr_entry = '{tag: key_q, utime: rtime_q, value: rvalue_q, hot: rhot_q};

	lcc_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk      (clk),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (work_slot_q),
		.wr_entry (wr_entry),
		.wr_stamp (now_q),
		.rd_entry (rd_entry),
		.rd_stamp (rd_stamp)
	);

	// Sequencer, counters and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			pend_found_q <= 1'b0;
			pend_slot_q  <= '0;
			queries_q    <= '0;
			hits_q       <= '0;
			warm_q       <= 1'b0;
			idx_q        <= '0;
			iss_s1       <= 1'b0;
			have_best_q  <= 1'b0;
			res_found_q  <= 1'b0;
			res_ev_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			evicted_q    <= 1'b0;
			warmed_q     <= 1'b0;
		end else begin
			iss_s1 <= issue && !look_done;
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						idx_q       <= '0;
						have_best_q <= 1'b0;
						res_found_q <= 1'b0;
						res_ev_q    <= 1'b0;
						unique case (mode)
							MODE_LOOKUP: begin
								queries_q <= sat_inc(queries_q);
								state_q   <= ST_LOOK;
							end
							MODE_CONFIRM: begin
								pend_found_q <= 1'b0;
								state_q      <= pend_found_q ? ST_CONF_RD : ST_RESULT;
							end
							MODE_DATA: begin
								pend_found_q <= 1'b0;
								if (pend_found_q) begin
									res_found_q <= 1'b1;
									state_q     <= ST_WRITE;
								end else if (fill_q < ENT_C) begin
									fill_q  <= fill_q + CNT_W'(1);
									state_q <= ST_WRITE;
								end else begin
									state_q <= ST_LRU;
								end
							end
							default: begin
								state_q <= ST_RESULT;
							end
						endcase
					end
				end
				ST_LOOK: begin
					if (look_done) begin
						res_found_q  <= match;
						pend_found_q <= match;
						pend_slot_q  <= match ? idx_s1 : '0;
						state_q      <= ST_RESULT;
					end
				end
				ST_LRU: begin
					if (lru_take) begin
						have_best_q <= 1'b1;
					end
					if (lru_done) begin
						res_ev_q <= 1'b1;
						if (!warm_q) begin
							warm_q    <= 1'b1;
							queries_q <= '0;
							hits_q    <= '0;
						end
						state_q <= ST_WRITE;
					end
				end
				ST_CONF_RD: begin
					state_q <= ST_CONF_WT;
				end
				ST_CONF_WT: begin
					hits_q      <= sat_inc(hits_q);
					res_found_q <= 1'b1;
					state_q     <= ST_RESULT;
				end
				ST_WRITE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						found_q   <= res_found_q;
						evicted_q <= res_ev_q;
						warmed_q  <= warm_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Output register: loaded from the result stage, drained by the consumer.
			if ((state_q == ST_RESULT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign res_slot_wide = WIDE_W'(res_slot_q);

	// Transaction fields, scan results and result payload.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (acc) begin
			key_q       <= item_key;
			now_q       <= now;
			rtime_q     <= reply_time;
			rvalue_q    <= reply_value;
			rhot_q      <= reply_hot;
			res_slot_q  <= '0;
			res_ctime_q <= '0;
			if (pend_found_q) begin
				work_slot_q <= pend_slot_q;
			end else begin
				work_slot_q <= fill_q[IDX_W-1:0];
			end
		end
		if (look_done) begin
			res_slot_q  <= match ? idx_s1 : '0;
			res_ctime_q <= match ? rd_entry.utime : '0;
		end
		if (lru_take) begin
			best_q       <= idx_s1;
			best_stamp_q <= rd_stamp;
		end
		if (lru_done) begin
			work_slot_q <= best_q;
		end
		if ((state_q == ST_CONF_WT) || (state_q == ST_WRITE)) begin
			res_slot_q <= work_slot_q;
		end
		if (state_q == ST_CONF_WT) begin
			res_ctime_q <= rd_entry.utime;
		end
		if (state_q == ST_WRITE) begin
			res_ctime_q <= rtime_q;
		end
		if ((state_q == ST_RESULT) && out_free) begin
			slot_q  <= res_slot_wide[SLOT_W-1:0];
			ctime_q <= res_ctime_q;
			qcnt_q  <= queries_q;
			hcnt_q  <= hits_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = found_q;
	assign slot        = slot_q;
	assign cached_time = ctime_q;
	assign query_count = qcnt_q;
	assign hit_count   = hcnt_q;
	assign evicted     = evicted_q;
	assign warmed      = warmed_q;

endmodule

[src/lcc_store.sv]
// Line memory and use-stamp memory of the LRU client cache.
// Depends on lcc_pkg; both memories have one write and one registered read port.
module lcc_store #(
	parameter int ENTRIES = 128,
	localparam int IDX_W = $clog2(ENTRIES)
) (
	input  logic                            clk,
	input  lcc_pkg::lcc_ctl_t               ctl,
	input  logic [IDX_W-1:0]                rd_addr,
	input  logic [IDX_W-1:0]                wr_addr,
	input  lcc_pkg::lcc_entry_t             wr_entry,
	input  logic [lcc_pkg::TIME_W-1:0]      wr_stamp,
	output lcc_pkg::lcc_entry_t             rd_entry,
	output logic [lcc_pkg::TIME_W-1:0]      rd_stamp
);
	import lcc_pkg::*;

	lcc_entry_t        entry_mem [ENTRIES];
	logic [TIME_W-1:0] stamp_mem [ENTRIES];

	// Line memory: written by data replies, read by lookups and confirms.
	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			entry_mem[wr_addr] <= wr_entry;
		end
		if (ctl.rd_en) begin
			rd_entry <= entry_mem[rd_addr];
		end
	end

	// Use-stamp memory: written by confirms and data replies, read by the victim scan.
	always_ff @(posedge clk) begin
		if (ctl.stamp_we) begin
			stamp_mem[wr_addr] <= wr_stamp;
		end
		if (ctl.rd_en) begin
			rd_stamp <= stamp_mem[rd_addr];
		end
	end

endmodule

[src/lcc_checker.sv]
// Port-level checks of the LRU client cache core, bound to the top level.
// Depends on lcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       found,
	input logic [lcc_pkg::SLOT_W-1:0] slot,
	input logic                       evicted,
	input logic                       warmed
);
	import lcc_pkg::*;

	// Only one transaction is worked on at a time.
	`CHK_ASSERT(a_one_in_flight, clk, arst_n, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

	// A data reply either overwrites the matched line or evicts, never both.
	`CHK_NEVER(a_found_and_evicted, clk, arst_n, rsp_valid && found && evicted, "found and evicted together")

	// An eviction always reports the warm state.
	`CHK_ASSERT(a_evict_warm, clk, arst_n, (rsp_valid && evicted) |-> warmed, "eviction without warm flag")

	// Once warm, the cache stays warm.
	`CHK_ASSERT(a_warm_sticky, clk, arst_n, (rsp_valid && rsp_ready && warmed) |=> warmed, "warm flag dropped")

	// A stalled response stays valid and holds its slot and found flag.
	`CHK_ASSERT(a_rsp_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(slot) && $stable(found)), "stalled response changed")

endmodule

bind lru_client_cache_with_validation_core lcc_checker u_lcc_checker (.*);

[sim/lru_client_cache_with_validation_core_tb.sv]
// Self-checking testbench for the fully associative LRU client cache core.
// Depends on lcc_pkg and lru_client_cache_with_validation_core; a mirror class predicts each reply.
`timescale 1ns / 100ps

module lru_client_cache_with_validation_core_tb;
	import lcc_pkg::*;

	localparam int SLOTS = 128;
	localparam int WATCHDOG_LIMIT = 20 * SLOTS;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// One request transaction and one reply transaction, field by field.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] rtime;
		logic [TIME_W-1:0] rvalue;
		logic              rhot;
	} cache_req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] ctime;
		logic [TIME_W-1:0] queries;
		logic [TIME_W-1:0] hits;
		logic              evicted;
		logic              warmed;
	} cache_rsp_t;

	// Mirror of the cache contents and counters; it predicts the reply of every
	// accepted request and compares it with the reply the block returns.
	class lru_cache_mirror;
		logic [KEY_W-1:0]  tags[SLOTS];
		bit                present[SLOTS];
		logic [TIME_W-1:0] utimes[SLOTS];
		logic [TIME_W-1:0] payloads[SLOTS];
		bit                kinds[SLOTS];
		logic [TIME_W-1:0] stamps[SLOTS];
		int unsigned       fill;
		int unsigned       held_slot;
		bit                held_hit;
		logic [TIME_W-1:0] queries;
		logic [TIME_W-1:0] hits;
		bit                warm;
		int unsigned       mismatch_count;
		cache_rsp_t        replies_due[$];

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				present[i] = 1'b0;
				tags[i] = '0;
				utimes[i] = '0;
				payloads[i] = '0;
				kinds[i] = 1'b0;
				stamps[i] = '0;
			end
			fill = 0;
			held_slot = 0;
			held_hit = 1'b0;
			queries = '0;
			hits = '0;
			warm = 1'b0;
			mismatch_count = 0;
		endfunction

		function logic [TIME_W-1:0] saturating_bump(logic [TIME_W-1:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		// Oldest use stamp wins; on equal stamps the lowest index stays chosen.
		function int unsigned lru_slot();
			int unsigned best;
			best = 0;
			for (int unsigned i = 1; i < SLOTS; i++)
				if (stamps[i] < stamps[best])
					best = i;
			return best;
		endfunction

		function bit holds(logic [KEY_W-1:0] key);
			for (int i = 0; i < SLOTS; i++)
				if (present[i] && tags[i] == key)
					return 1'b1;
			return 1'b0;
		endfunction

		function int unsigned outstanding();
			return replies_due.size();
		endfunction

		// Applies one accepted request and queues the reply it must produce.
		function void apply_request(cache_req_t r);
			cache_rsp_t e;
			bit matched;
			int unsigned s;
			e = '0;
			matched = 1'b0;
			s = 0;
			case (r.mode)
				MODE_LOOKUP: begin
					for (int unsigned i = 0; i < SLOTS; i++)
						if (!matched && present[i] && tags[i] == r.key) begin
							matched = 1'b1;
							s = i;
						end
					if (matched) begin
						e.found = 1'b1;
						e.slot = s[SLOT_W-1:0];
						e.ctime = utimes[s];
					end
					queries = saturating_bump(queries);
					held_hit = matched;
					held_slot = s;
				end
				MODE_CONFIRM: begin
					if (held_hit) begin
						e.found = 1'b1;
						e.slot = held_slot[SLOT_W-1:0];
						stamps[held_slot] = r.now;
						e.ctime = utimes[held_slot];
						hits = saturating_bump(hits);
					end
					held_hit = 1'b0;
				end
				MODE_DATA: begin
					if (held_hit) begin
						e.found = 1'b1;
						s = held_slot;
					end else if (fill < SLOTS) begin
						s = fill;
						fill++;
					end else begin
						s = lru_slot();
						e.evicted = 1'b1;
						// The first eviction restarts both counters.
						if (!warm) begin
							warm = 1'b1;
							queries = '0;
							hits = '0;
						end
					end
					tags[s] = r.key;
					utimes[s] = r.rtime;
					payloads[s] = r.rvalue;
					kinds[s] = r.rhot;
					stamps[s] = r.now;
					present[s] = 1'b1;
					e.slot = s[SLOT_W-1:0];
					e.ctime = r.rtime;
					held_hit = 1'b0;
				end
				default: begin
					// The unused mode leaves every piece of state alone.
				end
			endcase
			e.queries = queries;
			e.hits = hits;
			e.warmed = warm;
			replies_due.push_back(e);
		endfunction

		function void compare_field(string name, logic [TIME_W-1:0] want,
				logic [TIME_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatch_count++;
			end
		endfunction

		// Compares one accepted reply with the oldest prediction.
		function void check_reply(cache_rsp_t a);
			cache_rsp_t e;
			if (replies_due.size() == 0) begin
				$display("%0t: reply transaction with no request outstanding, actual %0h",
					$time, a);
				mismatch_count++;
				return;
			end
			e = replies_due.pop_front();
			compare_field("found", TIME_W'(e.found), TIME_W'(a.found));
			compare_field("slot", TIME_W'(e.slot), TIME_W'(a.slot));
			compare_field("cached_time", e.ctime, a.ctime);
			compare_field("query_count", e.queries, a.queries);
			compare_field("hit_count", e.hits, a.hits);
			compare_field("evicted", TIME_W'(e.evicted), TIME_W'(a.evicted));
			compare_field("warmed", TIME_W'(e.warmed), TIME_W'(a.warmed));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [MODE_W-1:0] mode = MODE_LOOKUP;
	logic [KEY_W-1:0]  item_key = '0;
	logic [TIME_W-1:0] now = '0;
	logic [TIME_W-1:0] reply_time = '0;
	logic [TIME_W-1:0] reply_value = '0;
	logic              reply_hot = 1'b0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic              found;
	logic [SLOT_W-1:0] slot;
	logic [TIME_W-1:0] cached_time;
	logic [TIME_W-1:0] query_count;
	logic [TIME_W-1:0] hit_count;
	logic              evicted;
	logic              warmed;

	lru_cache_mirror   mirror;
	int unsigned       send_idle_pct = 18;
	int unsigned       rsp_stall_pct = 46;
	int unsigned       quiet_cycles = 0;
	logic [TIME_W-1:0] tick = '0;

	lru_client_cache_with_validation_core #(
		.ENTRIES(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.mode(mode),
		.item_key(item_key),
		.now(now),
		.reply_time(reply_time),
		.reply_value(reply_value),
		.reply_hot(reply_hot),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.found(found),
		.slot(slot),
		.cached_time(cached_time),
		.query_count(query_count),
		.hit_count(hit_count),
		.evicted(evicted),
		.warmed(warmed)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reply side stalls at random.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	// Every accepted transaction is fed to the mirror at the edge that accepts it.
	always @(posedge clk) begin
		cache_rsp_t got;
		if (arst_n) begin
			if (req_valid && req_ready)
				mirror.apply_request('{mode, item_key, now, reply_time, reply_value, reply_hot});
			if (rsp_valid && rsp_ready) begin
				got = '{found, slot, cached_time, query_count, hit_count, evicted, warmed};
				mirror.check_reply(got);
			end
		end
	end

	// The run ends if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	function automatic cache_req_t pack_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
			logic [TIME_W-1:0] n, logic [TIME_W-1:0] t, logic [TIME_W-1:0] v, logic h);
		cache_req_t r;
		r.mode = m;
		r.key = k;
		r.now = n;
		r.rtime = t;
		r.rvalue = v;
		r.rhot = h;
		return r;
	endfunction

	// Use stamps mostly advance; some repeat to force LRU ties, a few jump anywhere.
	function automatic logic [TIME_W-1:0] next_now();
		int unsigned pick;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return $urandom;
		if (pick < 4)
			return tick;
		tick = tick + $urandom_range(1, 64);
		return tick;
	endfunction

	function automatic cache_req_t random_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
		return pack_req(m, k, next_now(), $urandom, $urandom, 1'($urandom_range(0, 1)));
	endfunction

	// Drives one request transaction; called and returning at a rising edge.
	task automatic send_request(cache_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= r.mode;
		item_key <= r.key;
		now <= r.now;
		reply_time <= r.rtime;
		reply_value <= r.rvalue;
		reply_hot <= r.rhot;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Hand-picked transactions: empty cache, protocol corners, field extremes.
	task automatic run_directed();
		send_request(pack_req(MODE_LOOKUP, 9'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_CONFIRM, 9'd0, 32'd7, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_UNUSED, 9'h1FF, '1, '1, '1, 1'b1));
		send_request(pack_req(MODE_DATA, 9'd0, 32'd0, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_LOOKUP, 9'd0, 32'd1, 32'd0, 32'd0, 1'b0));
		// The unused mode must not drop the pending match.
		send_request(pack_req(MODE_UNUSED, 9'd0, 32'd2, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_CONFIRM, 9'd0, '1, 32'd0, 32'd0, 1'b0));
		// A second reply sees no pending match.
		send_request(pack_req(MODE_CONFIRM, 9'd0, 32'd3, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_LOOKUP, 9'h1FF, 32'd4, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_DATA, 9'h1FF, '1, '1, '1, 1'b1));
		send_request(pack_req(MODE_LOOKUP, 9'h1FF, 32'd5, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_DATA, 9'h1FF, 32'd6, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
		send_request(pack_req(MODE_DATA, 9'h1FF, 32'd7, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
		// Two slots now hold the same key; the lower index must match.
		send_request(pack_req(MODE_LOOKUP, 9'h1FF, 32'd8, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_CONFIRM, 9'h1FF, 32'h5555_5555, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_DATA, 9'h155, 32'd9, '1, 32'd0, 1'b1));
		send_request(pack_req(MODE_LOOKUP, 9'h0AA, 32'd10, 32'd0, 32'd0, 1'b0));
		send_request(pack_req(MODE_DATA, 9'h0AA, 32'hAAAA_AAAA, 32'd1, '1, 1'b0));
		tick = 32'd16;
	endtask

	// Mostly lookup-then-reply pairs over a working set a little larger than the
	// cache, so that it fills and evicts; the rest is stray or broken traffic.
	task automatic run_traffic(int unsigned count);
		int unsigned sent;
		logic [KEY_W-1:0] key;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85) begin
				key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 511)) :
					KEY_W'($urandom_range(0, 199));
				send_request(random_req(MODE_LOOKUP, key));
				if (mirror.holds(key) && $urandom_range(0, 9) != 0)
					send_request(random_req(MODE_CONFIRM, key));
				else
					send_request(random_req(MODE_DATA, key));
				sent += 2;
			end else begin
				key = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 511)) :
					KEY_W'($urandom_range(0, 199));
				send_request(random_req(MODE_W'($urandom_range(0, 3)), key));
				sent += 1;
			end
		end
	endtask

	// Main sequence: reset, directed part, three idling phases, drain, verdict.
	initial begin
		mirror = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_traffic(500);
		send_idle_pct = 46;
		rsp_stall_pct = 18;
		run_traffic(500);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_traffic(500);
		req_valid <= 1'b0;
		while (mirror.outstanding() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mirror.mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[lru_client_cache_with_validation_core.f]
+incdir+src
src/lcc_pkg.sv
src/lcc_store.sv
src/lru_client_cache_with_validation_core.sv
src/lcc_checker.sv
sim/lru_client_cache_with_validation_core_tb.sv
